// File: rtl/pbr_pkg.sv
// Shared constants, types and helpers for the pose bbox rescale block.
// Used by pbr_div and pose_bbox_rescale_core; no dependencies.
package pbr_pkg;

    localparam int MAX_JOINTS = 32;
    localparam int JW         = $clog2(MAX_JOINTS);      // joint memory address bits
    localparam int CW         = $clog2(MAX_JOINTS + 1);  // joint count bits

    localparam int COORD_W = 16;   // Q1.14 input coordinate
    localparam int RATIO_W = 24;   // Q8.16 unsigned ratio
    localparam int OUT_W   = 24;   // Q9.14 result
    localparam int QUOT_W  = 32;   // full divider quotient

    typedef enum logic [1:0] {
        OP_LOAD_2D = 2'd0,
        OP_LOAD_3D = 2'd1,
        OP_EMIT    = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // max - min, negative taken as zero
    function automatic logic [COORD_W-1:0] span_of(input logic signed [COORD_W-1:0] hi,
                                                   input logic signed [COORD_W-1:0] lo);
        logic signed [COORD_W:0] d;
        d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        return d[COORD_W] ? '0 : d[COORD_W-1:0];
    endfunction

    // clamp a full quotient to the ratio range
    function automatic logic [RATIO_W-1:0] sat_ratio(input logic [QUOT_W-1:0] q);
        return (q[QUOT_W-1:RATIO_W] != '0) ? {RATIO_W{1'b1}} : q[RATIO_W-1:0];
    endfunction

    // a - b, saturated to the result width
    function automatic logic [OUT_W-1:0] sat_diff(input logic signed [OUT_W-1:0] a,
                                                  input logic signed [OUT_W-1:0] b);
        logic signed [OUT_W:0] d;
        d = {a[OUT_W-1], a} - {b[OUT_W-1], b};
        if (d[OUT_W] != d[OUT_W-1]) begin
            return d[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        return d[OUT_W-1:0];
    endfunction

endpackage

// File: rtl/pbr_div.sv
// Bit-serial restoring divider: (num << 16) / den, one quotient bit per cycle.
// Depends on pbr_pkg.
module pbr_div
    import pbr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [COORD_W-1:0]        num,
    input  logic [COORD_W-1:0]        den,
    output logic                      done,
    output logic [QUOT_W-1:0]         quot
);

    localparam int CNT_W = $clog2(QUOT_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [QUOT_W-1:0]    dvd_reg;
    logic [COORD_W-1:0]   rem_reg;
    logic [COORD_W-1:0]   den_reg;
    logic [QUOT_W-1:0]    quo_reg;

    logic [COORD_W:0]     rem_shift;
    logic                 ge;
    logic [COORD_W:0]     rem_sub;

    assign rem_shift = {rem_reg, dvd_reg[QUOT_W-1]};
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num, {(QUOT_W-COORD_W){1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[QUOT_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[COORD_W-1:0] : rem_shift[COORD_W-1:0];
            quo_reg <= {quo_reg[QUOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: rtl/pose_bbox_rescale_core.sv
// Pose bbox rescale: tracks 2D/3D bounds, stores 3D joints, emits rescaled pose.
// Depends on pbr_pkg and pbr_div.
//
// Flow: loads are taken back to back. An emit word with joints stored waits on the two
// bit-serial dividers (quotient bits, then done), then scales the pelvis, then runs
// memory read, multiply and subtract for each joint, plus any output stall. s_tready
// is low during an emit. An emit with no joints clears the bounds and gives no output.
// Reset (aresetn low, synchronous): clears bounds, joint count, FSM and output
// valid. The joint memory is not cleared; only written entries are ever used.
module pose_bbox_rescale_core
    import pbr_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // input words
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,    // coord_x [15:0], coord_y [31:16], coord_z [47:32]
    input  logic [1:0]    s_tuser,    // operation [1:0]
    // result words
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [71:0]   m_tdata,    // out_x [23:0], out_y [47:24], out_z [71:48]
    output logic          m_tlast,    // last_joint
    output logic          m_tuser     // span_error [0]
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,   // taking loads
        S_DIV  = 5'b00010,   // ratios in progress
        S_RD   = 5'b00100,   // joint read issued
        S_MUL  = 5'b01000,   // read data back, scale
        S_SUB  = 5'b10000    // pelvis capture or result out
    } state_t;

    localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // ---------------------------------------------------------------- state
    state_t                      state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [JW-1:0]               idx_reg, idx_next;
    logic                        pelvis_reg, pelvis_next;
    logic                        err_reg, err_next;
    logic [RATIO_W-1:0]          rx_reg, ry_reg;

    logic signed [COORD_W-1:0]   fminx_reg, fmaxx_reg, fminy_reg, fmaxy_reg;
    logic signed [COORD_W-1:0]   dminx_reg, dmaxx_reg, dminy_reg, dmaxy_reg;

    // joint memory, one 48-bit word per joint
    logic [47:0]                 joint_mem [MAX_JOINTS];
    logic [47:0]                 rd_data_reg;

    logic signed [OUT_W-1:0]     scx_reg, scy_reg, scz_reg;
    logic signed [OUT_W-1:0]     pvx_reg, pvy_reg, pvz_reg;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [71:0]                 m_tdata_reg;
    logic                        m_tlast_reg;
    logic                        m_tuser_reg;

    // ---------------------------------------------------------------- input decode
    logic                        s_accept;
    op_t                         op;
    logic signed [COORD_W-1:0]   in_x, in_y;
    logic                        store_full;
    logic                        do_load2d, do_load3d, do_emit;
    logic                        clear_all;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign op         = op_t'(s_tuser);
    assign in_x       = s_tdata[15:0];
    assign in_y       = s_tdata[31:16];
    assign store_full = (count_reg >= CW'(MAX_JOINTS));
    assign do_load2d  = s_accept && (op == OP_LOAD_2D);
    assign do_load3d  = s_accept && (op == OP_LOAD_3D) && !store_full;
    assign do_emit    = s_accept && (op == OP_EMIT);

    // ---------------------------------------------------------------- ratios
    logic [COORD_W-1:0] fspan_x, fspan_y, dspan_x, dspan_y;
    logic               div_start, div_done, div_done_y;
    logic [QUOT_W-1:0]  quot_x, quot_y;

    assign fspan_x   = span_of(fmaxx_reg, fminx_reg);
    assign fspan_y   = span_of(fmaxy_reg, fminy_reg);
    assign dspan_x   = span_of(dmaxx_reg, dminx_reg);
    assign dspan_y   = span_of(dmaxy_reg, dminy_reg);
    assign div_start = do_emit && (count_reg != '0);

    // zero divisor gives an all-ones quotient, which saturates as required
    pbr_div u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (fspan_x),
        .den     (dspan_x),
        .done    (div_done),
        .quot    (quot_x)
    );

    pbr_div u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (fspan_y),
        .den     (dspan_y),
        .done    (div_done_y),
        .quot    (quot_y)
    );

    // ---------------------------------------------------------------- scaling
    // 16-bit signed times 24-bit unsigned fits 40 bits; >>> 16 is a floor
    logic signed [40:0] prod_x, prod_y, prod_z;

    assign prod_x = $signed(rd_data_reg[15:0])  * $signed({1'b0, rx_reg});
    assign prod_y = $signed(rd_data_reg[31:16]) * $signed({1'b0, ry_reg});
    assign prod_z = $signed(rd_data_reg[47:32]) * $signed({1'b0, rx_reg});

    // ---------------------------------------------------------------- control
    logic out_free, m_load, is_last;

    assign out_free = !m_tvalid_reg || m_tready;
    assign is_last  = (idx_reg == JW'(count_reg - CW'(1)));
    assign m_load   = (state_reg == S_SUB) && !pelvis_reg && out_free;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        pelvis_next = pelvis_reg;
        err_next    = err_reg;
        clear_all   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (do_load3d) begin
                    count_next = count_reg + CW'(1);
                end
                if (do_emit) begin
                    idx_next    = '0;
                    pelvis_next = 1'b1;
                    err_next    = (dspan_x == '0) || (dspan_y == '0);
                    if (count_reg == '0) begin
                        clear_all = 1'b1;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_SUB;
            end
            S_SUB: begin
                if (pelvis_reg) begin
                    pelvis_next = 1'b0;
                    state_next  = S_RD;
                end else if (out_free) begin
                    if (is_last) begin
                        clear_all  = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + JW'(1);
                        state_next = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (clear_all) begin
            count_next = '0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            pelvis_reg   <= 1'b0;
            err_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            pelvis_reg   <= pelvis_next;
            err_reg      <= err_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // bounds: reset and emit both return them to the empty state
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_all) begin
            fminx_reg <= POS_MAX;
            fmaxx_reg <= NEG_MIN;
            fminy_reg <= POS_MAX;
            fmaxy_reg <= NEG_MIN;
            dminx_reg <= POS_MAX;
            dmaxx_reg <= NEG_MIN;
            dminy_reg <= POS_MAX;
            dmaxy_reg <= NEG_MIN;
        end else begin
            if (do_load2d) begin
                if (in_x < fminx_reg) fminx_reg <= in_x;
                if (in_x > fmaxx_reg) fmaxx_reg <= in_x;
                if (in_y < fminy_reg) fminy_reg <= in_y;
                if (in_y > fmaxy_reg) fmaxy_reg <= in_y;
            end
            if (do_load3d) begin
                if (in_x < dminx_reg) dminx_reg <= in_x;
                if (in_x > dmaxx_reg) dmaxx_reg <= in_x;
                if (in_y < dminy_reg) dminy_reg <= in_y;
                if (in_y > dmaxy_reg) dmaxy_reg <= in_y;
            end
        end
    end

    // joint memory: written by 3D loads while idle, read every cycle, read data used during emit
    always_ff @(posedge aclk) begin
        if (do_load3d) begin
            joint_mem[count_reg[JW-1:0]] <= s_tdata;
        end
        rd_data_reg <= joint_mem[idx_reg];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_DIV && div_done) begin
            rx_reg <= sat_ratio(quot_x);
            ry_reg <= sat_ratio(quot_y);
        end
        if (state_reg == S_MUL) begin
            scx_reg <= prod_x[39:16];
            scy_reg <= prod_y[39:16];
            scz_reg <= prod_z[39:16];
        end
        if (state_reg == S_SUB && pelvis_reg) begin
            pvx_reg <= scx_reg;
            pvy_reg <= scy_reg;
            pvz_reg <= scz_reg;
        end
        if (m_load) begin
            m_tdata_reg <= {sat_diff(scz_reg, pvz_reg),
                            sat_diff(scy_reg, pvy_reg),
                            sat_diff(scx_reg, pvx_reg)};
            m_tlast_reg <= is_last;
            m_tuser_reg <= err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------- checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_JOINTS))
        else $error("joint count beyond capacity");

    a_div_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done == div_done_y)
        else $error("ratio dividers out of step");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_MUL || state_reg == S_SUB)
        |-> ({1'b0, idx_reg} < count_reg))
        else $error("joint index past stored count");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_load && is_last) |=> (count_reg == '0 && state_reg == S_IDLE))
        else $error("emit did not clear load state");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside ratio phase");

endmodule
